// ===== rtl/fkes_pkg.sv =====
// fkes_pkg: shared types and constants of the Fisher-KPP Euler stencil unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package fkes_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes on the configuration port
   localparam logic REG_DIFFUSION_GAIN = 1'b0;
   localparam logic REG_TIME_STEP      = 1'b1;

   // 1.0 in Q4.12
   localparam logic signed [16:0] ONE_Q12 = 17'sd4096;
   // shift amount for the final rounding shift down from Q.40 to Q.12
   localparam int                 ROUND_SHIFT = 28;

   // window fill codes
   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_ONE   = 2'd1;
   localparam logic [1:0] FILL_FULL  = 2'd2;

   typedef struct packed {
      logic accept;     // item taken this cycle: shift window, first products
      logic mult;       // form the reaction product
      logic load_out;   // sum, round, saturate into the output register
   } cmd_type;

   typedef struct packed {
      logic window_full; // two samples held: next item yields a result
   } sts_type;

endpackage

// ===== rtl/fkes_ctrl.sv =====
// fkes_ctrl: sequencing state machine and output valid flag.
// Depends on fkes_pkg for the command and status structs.
`timescale 1ns / 1ps

module fkes_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  fkes_pkg::sts_type sts,
   output fkes_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MULT = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = accept;
      cmd.mult     = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.window_full) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.load_out || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/fkes_dp.sv =====
// fkes_dp: sample window, stencil products, rounding, saturation, result register.
// Depends on fkes_pkg for constants and the command and status structs.
`timescale 1ns / 1ps

module fkes_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fkes_pkg::cmd_type                    cmd,
   output fkes_pkg::sts_type                    sts,
   input  logic [fkes_pkg::SAMPLE_W-1:0]        sample,
   input  logic                                 is_last,
   input  logic [fkes_pkg::GAIN_W-1:0]          diffusion_gain,
   input  logic [fkes_pkg::GAIN_W-1:0]          time_step,
   output logic [fkes_pkg::SAMPLE_W-1:0]        new_value,
   output logic                                 row_done,
   output logic                                 saturated
);

   // window
   logic [15:0] left_ff, left_in;
   logic [15:0] centre_ff, centre_in;
   logic [1:0]  fill_ff, fill_in;

   // first stage
   logic signed [17:0] lap;
   logic signed [16:0] one_minus_c;
   logic signed [34:0] diff_prod;
   logic signed [32:0] cc_prod;
   logic signed [34:0] diff_ff;
   logic signed [32:0] cc_ff;
   logic        [15:0] c_ff;
   logic               last_ff;

   // second stage
   logic signed [49:0] react_ff, react_in;

   // final
   logic signed [50:0] sum;
   logic signed [22:0] inc;
   logic signed [23:0] v;
   logic        [15:0] value_in;
   logic               sat_in;

   logic [15:0] out_value_ff;
   logic        out_last_ff;
   logic        out_sat_ff;

   assign sts.window_full = (fill_ff == fkes_pkg::FILL_FULL);

   always_comb begin
      left_in   = left_ff;
      centre_in = centre_ff;
      fill_in   = fill_ff;
      if (cmd.accept) begin
         case (fill_ff)
            fkes_pkg::FILL_ONE: begin
               centre_in = sample;
               fill_in   = is_last ? fkes_pkg::FILL_EMPTY : fkes_pkg::FILL_FULL;
            end
            fkes_pkg::FILL_FULL: begin
               left_in   = centre_ff;
               centre_in = sample;
               fill_in   = is_last ? fkes_pkg::FILL_EMPTY : fkes_pkg::FILL_FULL;
            end
            default: begin
               left_in = sample;
               fill_in = is_last ? fkes_pkg::FILL_EMPTY : fkes_pkg::FILL_ONE;
            end
         endcase
      end
   end

   // left - 2c + right, then r * lap and c * (1 - c)
   assign lap = $signed({{2{left_ff[15]}}, left_ff})
              + $signed({{2{sample[15]}}, sample})
              - $signed({centre_ff[15], centre_ff, 1'b0});
   assign diff_prod   = $signed({1'b0, diffusion_gain}) * lap;
   assign one_minus_c = fkes_pkg::ONE_Q12 - $signed({centre_ff[15], centre_ff});
   assign cc_prod     = $signed({centre_ff[15], centre_ff}) * one_minus_c;

   assign react_in = $signed({1'b0, time_step}) * cc_ff;

   // diffusion scaled to Q.40, plus reaction, round half up, floor shift
   assign sum = $signed({{4{diff_ff[34]}}, diff_ff, 12'b0})
              + $signed({react_ff[49], react_ff})
              + (51'sd1 <<< (fkes_pkg::ROUND_SHIFT - 1));
   assign inc = sum[50:fkes_pkg::ROUND_SHIFT];
   assign v   = $signed({{8{c_ff[15]}}, c_ff}) + $signed({inc[22], inc});

   always_comb begin
      if (v > 24'sd32767) begin
         value_in = 16'h7FFF;
         sat_in   = 1'b1;
      end else if (v < -24'sd32768) begin
         value_in = 16'h8000;
         sat_in   = 1'b1;
      end else begin
         value_in = v[15:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         centre_ff <= '0;
         fill_ff   <= fkes_pkg::FILL_EMPTY;
      end else begin
         left_ff   <= left_in;
         centre_ff <= centre_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         diff_ff <= diff_prod;
         cc_ff   <= cc_prod;
         c_ff    <= centre_ff;
         last_ff <= is_last;
      end
      if (cmd.mult) begin
         react_ff <= react_in;
      end
      if (cmd.load_out) begin
         out_value_ff <= value_in;
         out_last_ff  <= last_ff;
         out_sat_ff   <= sat_in;
      end
   end

   assign new_value = out_value_ff;
   assign row_done  = out_last_ff;
   assign saturated = out_sat_ff;

endmodule

// ===== rtl/fisher_kpp_euler_stencil_unit.sv =====
// Fisher-KPP forward Euler three-point stencil unit, top level.
// An item that completes a stencil registers r*lap and c*(1-c); state MULT forms dt*c*(1-c),
// and state SUM, which waits while a result stalls on rsp, loads the result register. Items
// come one per cycle while the window fills, then no new item is taken until SUM is done.
// Reset (synchronous, active high) empties the window and clears both gains.
`timescale 1ns / 1ps

module fisher_kpp_euler_stencil_unit (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample (signed Q4.12)
   input  logic        req_tlast,   // is_last: right boundary, ends the row
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] new_value (signed Q4.12)
   output logic        rsp_tlast,   // row_done: last interior point of the row
   output logic        rsp_tuser,   // [0] saturated
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fkes_pkg::cmd_type cmd;
   fkes_pkg::sts_type sts;

   // Gains: r = dt/dx^2 at byte 0, dt at byte 4; only paddr[2] decodes.
   logic [15:0] diffusion_gain_ff, diffusion_gain_in;
   logic [15:0] time_step_ff, time_step_in;
   logic        csr_write;
   logic        csr_sel;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_comb begin
      diffusion_gain_in = diffusion_gain_ff;
      time_step_in      = time_step_ff;
      if (csr_write) begin
         case (csr_sel)
            fkes_pkg::REG_DIFFUSION_GAIN: diffusion_gain_in = csr_pwdata[15:0];
            fkes_pkg::REG_TIME_STEP:      time_step_in      = csr_pwdata[15:0];
            default: begin
               diffusion_gain_in = diffusion_gain_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         fkes_pkg::REG_DIFFUSION_GAIN: csr_prdata = {16'b0, diffusion_gain_ff};
         fkes_pkg::REG_TIME_STEP:      csr_prdata = {16'b0, time_step_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diffusion_gain_ff <= '0;
         time_step_ff      <= '0;
      end else begin
         diffusion_gain_ff <= diffusion_gain_in;
         time_step_ff      <= time_step_in;
      end
   end

   // Controller: IDLE takes items; a full window sends it through MULT and SUM.
   fkes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: window, products, round and clip, result register.
   fkes_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sample         (req_tdata),
      .is_last        (req_tlast),
      .diffusion_gain (diffusion_gain_ff),
      .time_step      (time_step_ff),
      .new_value      (rsp_tdata),
      .row_done       (rsp_tlast),
      .saturated      (rsp_tuser)
   );

endmodule

// ===== rtl/fkes_checker.sv =====
// fkes_checker: port-level temporal checks of the stencil unit.
// Bound to fisher_kpp_euler_stencil_unit; no package dependency.
`timescale 1ns / 1ps

module fkes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // no result pending right after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // unit is ready for items right after reset
   a_rst_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

   // a fresh result follows an earlier accepted item
   a_rise_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result without matching item");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind fisher_kpp_euler_stencil_unit fkes_checker u_fkes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
